FILE: rtl/pne_pkg.sv
// Shared types, constants and helpers for the path name escape encoder.
package pne_pkg;

  localparam int unsigned MaxRes  = 6;
  localparam int unsigned CntW    = 3;

  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
    logic                   nul;
  } res_list_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h61 + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

FILE: rtl/pne_expand.sv
// Expansion of one path byte into its result list, with the element state.
module pne_expand import pne_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      split_i,
  input  logic      adv_i,
  input  logic [7:0] byte_i,
  input  logic      eon_i,
  output res_list_t list_o
);

  logic open_q, open_d;
  logic pend_q, pend_d;

  always_comb begin
    logic [CntW-1:0] n;
    n      = '0;
    list_o = '0;
    open_d = open_q;
    pend_d = pend_q;
    if (split_i && byte_i == ChSlash) begin
      open_d = 1'b0;
      pend_d = 1'b1;
    end else begin
      if (pend_q) begin
        list_o.bytes[n] = ChSlash;
        n = n + 1'b1;
        pend_d = 1'b0;
      end
      if (!open_q) begin
        list_o.bytes[n] = ChF;
        n = n + 1'b1;
        open_d = 1'b1;
      end
      if (byte_i == ChPct || byte_i == ChSlash || byte_i == ChLf || byte_i == ChCr) begin
        list_o.bytes[n] = ChPct;
        n = n + 1'b1;
        list_o.bytes[n] = hex_char(byte_i[7:4]);
        n = n + 1'b1;
        list_o.bytes[n] = hex_char(byte_i[3:0]);
        n = n + 1'b1;
      end else begin
        list_o.bytes[n] = byte_i;
        n = n + 1'b1;
      end
    end
    if (eon_i) begin
      list_o.bytes[n] = ChNul;
      n = n + 1'b1;
      list_o.nul = 1'b1;
      open_d = 1'b0;
      pend_d = 1'b0;
    end
    list_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      pend_q <= 1'b0;
    end else if (adv_i) begin
      open_q <= open_d;
      pend_q <= pend_d;
    end
  end

endmodule

FILE: rtl/pne_emit.sv
// Result list register, shifted out one result byte per cycle while the output is not stalled.
module pne_emit import pne_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_list_t list_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic [7:0] out_byte_o,
  output logic      last_of_run_o,
  output logic      name_done_o
);

  logic [MaxRes-1:0][7:0] buf_q, buf_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   nul_q, nul_d;
  logic                   pop;

  assign out_valid_o   = (cnt_q != '0);
  assign pop           = out_valid_o && !out_stall_i;
  assign last_of_run_o = (cnt_q == CntW'(1));
  assign name_done_o   = nul_q && last_of_run_o;
  assign out_byte_o    = buf_q[0];
  assign free_o        = (cnt_q == '0) || (last_of_run_o && pop);

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    nul_d = nul_q;
    if (load_i) begin
      buf_d = list_i.bytes;
      cnt_d = list_i.cnt;
      nul_d = list_i.nul;
    end else if (pop) begin
      buf_d = {8'h00, buf_q[MaxRes-1:1]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      nul_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      nul_q <= nul_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

FILE: rtl/path_name_escape_encoder.sv
// Top level of the path name escape encoder: input register, expansion, result output.
// Path bytes go through an input register and are expanded into a list of up to six
// result bytes ('/', 'f', the byte or its %xx escape, NUL) held in a result register
// that shifts out one result per cycle unless out_stall_i is high. An input request whose
// byte makes one result or none passes at one per cycle unless the output stalls; one
// making more holds the input until its last result is taken, so the sustained rate is
// set by the output port at one result byte per cycle. split_at_slash resets to 1.
module path_name_escape_encoder import pne_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_split_at_slash_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_name_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       name_done_o
);

  logic       split_q;
  logic       iv_q, iv_d;
  logic [7:0] ib_q;
  logic       ie_q;
  logic       free, adv, accept;
  res_list_t  list;

  assign cfg_ready_o = 1'b1;
  assign adv         = iv_q && free;
  assign in_stall_o  = iv_q && !free;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    iv_d = iv_q;
    if (accept) begin
      iv_d = 1'b1;
    end else if (adv) begin
      iv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= 1'b1;
      iv_q    <= 1'b0;
    end else begin
      iv_q <= iv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        split_q <= cfg_split_at_slash_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ib_q <= in_byte_i;
      ie_q <= end_of_name_i;
    end
  end

  pne_expand u_expand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .split_i (split_q),
    .adv_i   (adv),
    .byte_i  (ib_q),
    .eon_i   (ie_q),
    .list_o  (list)
  );

  pne_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (adv && (list.cnt != '0)),
    .list_i        (list),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .name_done_o   (name_done_o)
  );

endmodule
